@@ sv/rbs_pkg.sv @@
// Package for the ray / box slab intersection block.
// Holds default word and fraction widths; no dependencies.
`default_nettype none
package rbs_pkg;
  localparam int WordBitsDef = 32;
  localparam int FracBitsDef = 16;
endpackage
`default_nettype wire

@@ sv/rbs_slab_prep.sv @@
// One axis of the front stage: slab numerators, divisor magnitude, parallel and origin-in-slab checks.
// Depends on rbs_pkg for default widths.
`default_nettype none
module rbs_slab_prep #(
  parameter int WORD_BITS = rbs_pkg::WordBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic signed [WORD_BITS-1:0] origin_i,
  input  wire logic signed [WORD_BITS-1:0] dir_i,
  input  wire logic signed [WORD_BITS-1:0] min_i,
  input  wire logic signed [WORD_BITS-1:0] max_i,
  output logic             [WORD_BITS:0]   lo_mag_o,
  output logic                             lo_neg_o,
  output logic             [WORD_BITS:0]   hi_mag_o,
  output logic                             hi_neg_o,
  output logic             [WORD_BITS-1:0] den_o,
  output logic                             par_o,
  output logic                             pok_o
);
  import rbs_pkg::*;

  logic signed [WORD_BITS:0] dlo, dhi;
  logic                      dneg;

  always_comb begin
    dlo  = {min_i[WORD_BITS-1], min_i} - {origin_i[WORD_BITS-1], origin_i};
    dhi  = {max_i[WORD_BITS-1], max_i} - {origin_i[WORD_BITS-1], origin_i};
    dneg = dir_i[WORD_BITS-1];
  end

  always_ff @(posedge clk_i) begin
    lo_mag_o <= dlo[WORD_BITS] ? $unsigned(-dlo) : $unsigned(dlo);
    hi_mag_o <= dhi[WORD_BITS] ? $unsigned(-dhi) : $unsigned(dhi);
    lo_neg_o <= dlo[WORD_BITS] ^ dneg;
    hi_neg_o <= dhi[WORD_BITS] ^ dneg;
    den_o    <= dneg ? $unsigned(-dir_i) : $unsigned(dir_i);
    par_o    <= (dir_i == '0);
    pok_o    <= (origin_i >= min_i) && (origin_i <= max_i);
  end
endmodule
`default_nettype wire

@@ sv/rbs_slab_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, saturating signed result.
// Depends on rbs_pkg for default widths.
`default_nettype none
module rbs_slab_div #(
  parameter int WORD_BITS = rbs_pkg::WordBitsDef,
  parameter int FRAC_BITS = rbs_pkg::FracBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic        [WORD_BITS:0]   num_i,
  input  wire logic                        neg_i,
  input  wire logic        [WORD_BITS-1:0] den_i,
  output logic signed      [WORD_BITS-1:0] quo_o
);
  import rbs_pkg::*;

  localparam int NW    = WORD_BITS + 1 + FRAC_BITS;
  localparam int STEPS = WORD_BITS - 1;

  logic [NW-1:0]        n_full, n_top;
  logic                 sat0;
  logic [WORD_BITS-1:0] rem_q [STEPS+1];
  logic [WORD_BITS-2:0] low_q [STEPS+1];
  logic [WORD_BITS-2:0] quo_q [STEPS+1];
  logic [WORD_BITS-1:0] den_q [STEPS+1];
  logic                 sat_q [STEPS+1];
  logic                 neg_q [STEPS+1];

  // Quotient reaches the half range exactly when the top part is not below the divisor.
  always_comb begin
    n_full = {num_i, {FRAC_BITS{1'b0}}};
    n_top  = n_full >> STEPS;
    sat0   = (n_top >= NW'(den_i));
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= sat0 ? '0 : n_top[WORD_BITS-1:0];
    low_q[0] <= n_full[WORD_BITS-2:0];
    quo_q[0] <= '0;
    den_q[0] <= den_i;
    sat_q[0] <= sat0;
    neg_q[0] <= neg_i;
  end

  for (genvar s = 1; s <= STEPS; s++) begin : g_step
    logic [WORD_BITS-1:0] r2;
    logic                 ge;
    always_comb begin
      r2 = {rem_q[s-1][WORD_BITS-2:0], low_q[s-1][WORD_BITS-2]};
      ge = (r2 >= den_q[s-1]);
    end
    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? (r2 - den_q[s-1]) : r2;
      low_q[s] <= {low_q[s-1][WORD_BITS-3:0], 1'b0};
      quo_q[s] <= {quo_q[s-1][WORD_BITS-3:0], ge};
      den_q[s] <= den_q[s-1];
      sat_q[s] <= sat_q[s-1];
      neg_q[s] <= neg_q[s-1];
    end
  end

  logic signed [WORD_BITS-1:0] mag;
  always_comb mag = {1'b0, quo_q[STEPS]};

  always_ff @(posedge clk_i) begin
    if (sat_q[STEPS]) begin
      quo_o <= neg_q[STEPS] ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
    end else begin
      quo_o <= neg_q[STEPS] ? -mag : mag;
    end
  end
endmodule
`default_nettype wire

@@ sv/rbs_combine.sv @@
// Back end: orders slab distances per axis, reduces to t_near / t_far, decides hit.
// Depends on rbs_pkg for default widths.
`default_nettype none
module rbs_combine #(
  parameter int WORD_BITS = rbs_pkg::WordBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire logic signed [WORD_BITS-1:0] t0_i [3],
  input  wire logic signed [WORD_BITS-1:0] t1_i [3],
  input  wire logic        [2:0]           par_i,
  input  wire logic        [2:0]           pok_i,
  output logic                             done_o,
  output logic                             hit_o,
  output logic signed      [WORD_BITS-1:0] t_near_o
);
  import rbs_pkg::*;

  localparam logic signed [WORD_BITS-1:0] TMin = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic signed [WORD_BITS-1:0] TMax = {1'b0, {(WORD_BITS-1){1'b1}}};

  logic signed [WORD_BITS-1:0] en_d [3], ex_d [3];
  logic signed [WORD_BITS-1:0] en_q [3], ex_q [3];
  logic                        miss_q, valid_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (par_i[a]) begin
        en_d[a] = TMin;
        ex_d[a] = TMax;
      end else if (t0_i[a] < t1_i[a]) begin
        en_d[a] = t0_i[a];
        ex_d[a] = t1_i[a];
      end else begin
        en_d[a] = t1_i[a];
        ex_d[a] = t0_i[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    en_q   <= en_d;
    ex_q   <= ex_d;
    miss_q <= |(par_i & ~pok_i);
  end

  logic signed [WORD_BITS-1:0] tn, tf, tn01, tf01;
  logic                        hit_d;

  always_comb begin
    tn01  = (en_q[0] > en_q[1]) ? en_q[0] : en_q[1];
    tn    = (tn01 > en_q[2]) ? tn01 : en_q[2];
    tf01  = (ex_q[0] < ex_q[1]) ? ex_q[0] : ex_q[1];
    tf    = (tf01 < ex_q[2]) ? tf01 : ex_q[2];
    hit_d = !miss_q && !(tn > tf) && !tf[WORD_BITS-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_o    <= hit_d;
    t_near_o <= hit_d ? tn : '0;
  end
endmodule
`default_nettype wire

@@ sv/ray_box_slab_intersection.sv @@
// Ray / axis-aligned box slab test, fully pipelined.
// Throughput: one beat per cycle; busy_o stays low, since the receiver cannot stall.
// Depth is set by the slab dividers, which resolve one quotient bit per stage.
// Reset (rst_ni, async, active low) clears only the valid and side-line registers; no beat is in flight after it.
`default_nettype none
module ray_box_slab_intersection #(
  parameter int WORD_BITS = rbs_pkg::WordBitsDef,
  parameter int FRAC_BITS = rbs_pkg::FracBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic signed [WORD_BITS-1:0] origin_x_i,
  input  wire logic signed [WORD_BITS-1:0] origin_y_i,
  input  wire logic signed [WORD_BITS-1:0] origin_z_i,
  input  wire logic signed [WORD_BITS-1:0] dir_x_i,
  input  wire logic signed [WORD_BITS-1:0] dir_y_i,
  input  wire logic signed [WORD_BITS-1:0] dir_z_i,
  input  wire logic signed [WORD_BITS-1:0] box_min_x_i,
  input  wire logic signed [WORD_BITS-1:0] box_min_y_i,
  input  wire logic signed [WORD_BITS-1:0] box_min_z_i,
  input  wire logic signed [WORD_BITS-1:0] box_max_x_i,
  input  wire logic signed [WORD_BITS-1:0] box_max_y_i,
  input  wire logic signed [WORD_BITS-1:0] box_max_z_i,
  output logic                             done_o,
  output logic                             hit_o,
  output logic signed      [WORD_BITS-1:0] t_near_o
);
  import rbs_pkg::*;

  localparam int DivLat = WORD_BITS + 1;
  localparam int Lat    = WORD_BITS + 4;

  // Never hold off a beat: every stage advances each cycle.
  assign busy_o = 1'b0;

  logic signed [WORD_BITS-1:0] org [3], dir [3], bmin [3], bmax [3];
  always_comb begin
    org  = '{origin_x_i, origin_y_i, origin_z_i};
    dir  = '{dir_x_i, dir_y_i, dir_z_i};
    bmin = '{box_min_x_i, box_min_y_i, box_min_z_i};
    bmax = '{box_max_x_i, box_max_y_i, box_max_z_i};
  end

  logic                 prep_valid_q;
  logic [WORD_BITS:0]   lo_mag [3], hi_mag [3];
  logic                 lo_neg [3], hi_neg [3];
  logic [WORD_BITS-1:0] den [3];
  logic [2:0]           par, pok;
  logic signed [WORD_BITS-1:0] t0 [3], t1 [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
    end else begin
      prep_valid_q <= start_i && !busy_o;
    end
  end

  // Per axis: numerators and divisor, then two slab dividers in parallel.
  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbs_slab_prep #(.WORD_BITS(WORD_BITS)) u_prep (
      .clk_i    (clk_i),
      .origin_i (org[a]),
      .dir_i    (dir[a]),
      .min_i    (bmin[a]),
      .max_i    (bmax[a]),
      .lo_mag_o (lo_mag[a]),
      .lo_neg_o (lo_neg[a]),
      .hi_mag_o (hi_mag[a]),
      .hi_neg_o (hi_neg[a]),
      .den_o    (den[a]),
      .par_o    (par[a]),
      .pok_o    (pok[a])
    );

    rbs_slab_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_lo (
      .clk_i (clk_i),
      .num_i (lo_mag[a]),
      .neg_i (lo_neg[a]),
      .den_i (den[a]),
      .quo_o (t0[a])
    );

    rbs_slab_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_hi (
      .clk_i (clk_i),
      .num_i (hi_mag[a]),
      .neg_i (hi_neg[a]),
      .den_i (den[a]),
      .quo_o (t1[a])
    );
  end

  // Side line: carry valid and the parallel-axis flags alongside the dividers.
  logic [6:0] side_q [DivLat];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DivLat; s++) side_q[s] <= '0;
    end else begin
      side_q[0] <= {prep_valid_q, par, pok};
      for (int s = 1; s < DivLat; s++) side_q[s] <= side_q[s-1];
    end
  end

  rbs_combine #(.WORD_BITS(WORD_BITS)) u_combine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (side_q[DivLat-1][6]),
    .t0_i     (t0),
    .t1_i     (t1),
    .par_i    (side_q[DivLat-1][5:3]),
    .pok_i    (side_q[DivLat-1][2:0]),
    .done_o   (done_o),
    .hit_o    (hit_o),
    .t_near_o (t_near_o)
  );

  // A result beat comes only from a matching earlier start beat.
  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Lat))
    else $error("done_o without matching start");

  // A miss reports a zero distance.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (t_near_o == '0))
    else $error("miss with nonzero t_near");

  // Valid line holds at most what entered: nothing leaves the prep stage without a start.
  a_prep_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prep_valid_q |-> $past(start_i))
    else $error("prep stage valid without start");
endmodule
`default_nettype wire

@@ bench/ray_box_slab_intersection_tb.sv @@
// Testbench for the ray / box slab intersection block: directed and random rays,
// checked against a behavioral slab predictor. Depends on rbs_pkg and the block RTL.
`timescale 1ns / 1ps
`default_nettype none
module ray_box_slab_intersection_tb;
  import rbs_pkg::*;

  localparam int WB = WordBitsDef;
  localparam int FB = FracBitsDef;
  localparam int PIPE_DEPTH = WB + 4;
  localparam logic signed [63:0] T_MAX = 64'sd2147483647;
  localparam logic signed [63:0] T_MIN = -64'sd2147483648;
  localparam int ONE = 32'sh00010000;
  localparam int MX = 32'sh7fffffff;
  localparam int MN = 32'sh80000000;

  // One ray / box query.
  typedef struct packed {
    logic signed [WB-1:0] ox, oy, oz;
    logic signed [WB-1:0] dx, dy, dz;
    logic signed [WB-1:0] lx, ly, lz;
    logic signed [WB-1:0] hx, hy, hz;
  } ray_query_t;

  typedef struct packed {
    logic                 hit;
    logic signed [WB-1:0] t_near;
  } hit_info_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  ray_query_t drv_q = '0;
  logic busy_o, done_o, hit_o;
  logic signed [WB-1:0] t_near_o;

  ray_query_t pending_queries[$];
  hit_info_t  expected_hits[$];
  int n_fail = 0;
  int n_checked = 0;
  int n_hits = 0;
  int gap_left = 0;
  bit stim_done = 1'b0;

  always #10 clk_i = ~clk_i;

  ray_box_slab_intersection u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .origin_x_i(drv_q.ox), .origin_y_i(drv_q.oy), .origin_z_i(drv_q.oz),
    .dir_x_i(drv_q.dx), .dir_y_i(drv_q.dy), .dir_z_i(drv_q.dz),
    .box_min_x_i(drv_q.lx), .box_min_y_i(drv_q.ly), .box_min_z_i(drv_q.lz),
    .box_max_x_i(drv_q.hx), .box_max_y_i(drv_q.hy), .box_max_z_i(drv_q.hz),
    .done_o(done_o), .hit_o(hit_o), .t_near_o(t_near_o)
  );

  // Append a query to the pending list.
  function automatic void add_query(ray_query_t rq);
    pending_queries = {pending_queries, rq};
  endfunction

  // Saturated fixed-point quotient num * 2^FB / den, truncated toward zero.
  function automatic logic signed [63:0] slab_distance(logic signed [63:0] num,
                                                       logic signed [63:0] den);
    logic neg;
    logic [127:0] an, ad, q;
    neg = (num < 0) != (den < 0);
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = (an << FB) / ad;
    if (neg) return (q > 128'd2147483648) ? T_MIN : -$signed({1'b0, q[62:0]});
    return (q > 128'd2147483647) ? T_MAX : $signed({1'b0, q[62:0]});
  endfunction

  function automatic hit_info_t predict_hit(ray_query_t r);
    logic signed [63:0] o[3], d[3], lo[3], hi[3];
    logic signed [63:0] t_in, t_out, t0, t1;
    logic miss;
    hit_info_t res;
    o = '{r.ox, r.oy, r.oz};
    d = '{r.dx, r.dy, r.dz};
    lo = '{r.lx, r.ly, r.lz};
    hi = '{r.hx, r.hy, r.hz};
    t_in = T_MIN;
    t_out = T_MAX;
    miss = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (d[a] == 0) begin
        // Parallel slab: pass only with the origin between the planes.
        if (o[a] < lo[a] || o[a] > hi[a]) miss = 1'b1;
      end else begin
        t0 = slab_distance(lo[a] - o[a], d[a]);
        t1 = slab_distance(hi[a] - o[a], d[a]);
        if (t0 > t1) begin
          t_in = (t1 > t_in) ? t1 : t_in;
          t_out = (t0 < t_out) ? t0 : t_out;
        end else begin
          t_in = (t0 > t_in) ? t0 : t_in;
          t_out = (t1 < t_out) ? t1 : t_out;
        end
      end
    end
    if (t_in > t_out || t_out < 0) miss = 1'b1;
    res.hit = !miss;
    res.t_near = miss ? '0 : t_in[WB-1:0];
    return res;
  endfunction

  function automatic logic signed [WB-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      1: return '0;
      2, 3: return $signed($urandom());
      default: return $signed($urandom_range(0, 32'h00280000)) - 32'sh00140000;
    endcase
  endfunction

  function automatic logic signed [WB-1:0] rand_dir();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $signed($urandom());
      3: return $signed($urandom_range(1, 16)) * ($urandom_range(0, 1) ? 1 : -1);
      default: return $signed($urandom_range(0, 32'h00040000)) - 32'sh00020000;
    endcase
  endfunction

  // Mostly well-formed boxes at random centres; the rest have wild, possibly inverted, bounds.
  function automatic ray_query_t rand_query();
    ray_query_t r;
    logic signed [WB-1:0] c[3], e[3];
    r.ox = rand_coord(); r.oy = rand_coord(); r.oz = rand_coord();
    r.dx = rand_dir(); r.dy = rand_dir(); r.dz = rand_dir();
    for (int a = 0; a < 3; a++) begin
      c[a] = rand_coord();
      e[a] = $urandom_range(0, 32'h00080000);
    end
    if ($urandom_range(0, 9) < 8) begin
      r.lx = c[0] - e[0]; r.hx = c[0] + e[0];
      r.ly = c[1] - e[1]; r.hy = c[1] + e[1];
      r.lz = c[2] - e[2]; r.hz = c[2] + e[2];
    end else begin
      r.lx = rand_coord(); r.hx = rand_coord();
      r.ly = rand_coord(); r.hy = rand_coord();
      r.lz = rand_coord(); r.hz = rand_coord();
    end
    return r;
  endfunction

  function automatic ray_query_t mk(int ox, int oy, int oz, int dx, int dy, int dz,
                                    int lx, int ly, int lz, int hx, int hy, int hz);
    return '{ox, oy, oz, dx, dy, dz, lx, ly, lz, hx, hy, hz};
  endfunction

  initial begin
    ray_query_t r;
    // Plain hit along +x, hit from inside, miss behind, miss sideways.
    add_query(mk(0, 0, 0, ONE, 0, 0, 2*ONE, -ONE, -ONE, 3*ONE, ONE, ONE));
    add_query(mk(0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    add_query(mk(0, 0, 0, -ONE, 0, 0, 2*ONE, -ONE, -ONE, 3*ONE, ONE, ONE));
    add_query(mk(0, 5*ONE, 0, ONE, 0, 0, 2*ONE, -ONE, -ONE, 3*ONE, ONE, ONE));
    // All axes parallel, origin inside and outside.
    add_query(mk(0, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    add_query(mk(2*ONE, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    // Origin on the box faces with parallel axes.
    add_query(mk(ONE, -ONE, 0, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    // Inverted box, moving and parallel.
    add_query(mk(0, 0, 0, ONE, ONE, ONE, 3*ONE, 3*ONE, 3*ONE, ONE, ONE, ONE));
    add_query(mk(0, 0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE));
    // Zero numerator, touching the ray start.
    add_query(mk(0, 0, 0, ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE));
    // Saturation: tiny directions, huge spans, extreme fields.
    add_query(mk(0, 0, 0, 1, 1, 1, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE));
    add_query(mk(MN, MN, MN, 1, 1, 1, MN, MN, MN, MX, MX, MX));
    add_query(mk(MX, MX, MX, -1, -1, -1, MN, MN, MN, MX, MX, MX));
    add_query(mk(MN, 0, 0, MX, 0, 0, MN, MN, MN, MX, MX, MX));
    add_query(mk(MX, 0, 0, MN, MX, MN, MN, MN, MN, MX, MX, MX));
    add_query(mk(0, 0, 0, MN, MN, MN, MN, MN, MN, 0, 0, 0));
    add_query(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    add_query(mk(MX, MX, MX, MX, MX, MX, MX, MX, MX, MX, MX, MX));
    add_query(mk(MN, MN, MN, MN, MN, MN, MN, MN, MN, MN, MN, MN));
    for (int i = 0; i < 740; i++) begin
      r = rand_query();
      add_query(r);
    end
  end

  // Driver: present one beat per accept, with random gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_hits = {expected_hits, predict_hit(drv_q)};
      end
      if (start_i && busy_o) begin
        // hold the beat until accepted
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start_i <= 1'b0;
      end else if (pending_queries.size() > 0) begin
        drv_q <= pending_queries.pop_front();
        start_i <= 1'b1;
        if ($urandom_range(0, 3) == 0)
          gap_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        else if ($urandom_range(0, 49) == 0)
          gap_left <= 0;
      end else begin
        start_i <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // Monitor: compare each done beat with the oldest prediction.
  always @(posedge clk_i) begin
    hit_info_t exp_r;
    if (rst_ni && done_o) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected beat hit=%0b t_near=%0d", $time, hit_o, t_near_o);
        n_fail <= n_fail + 1;
      end else begin
        exp_r = expected_hits.pop_front();
        n_checked <= n_checked + 1;
        if (exp_r.hit) n_hits <= n_hits + 1;
        if (hit_o !== exp_r.hit || t_near_o !== exp_r.t_near) begin
          $display("%0t: mismatch expected hit=%0b t_near=%0d actual hit=%0b t_near=%0d",
                   $time, exp_r.hit, exp_r.t_near, hit_o, t_near_o);
          n_fail <= n_fail + 1;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done);
    wait (expected_hits.size() == 0);
    repeat (2 * PIPE_DEPTH) @(posedge clk_i);
    $display("Checked %0d ray/box queries, %0d hits and %0d misses.",
             n_checked, n_hits, n_checked - n_hits);
    if (n_fail == 0 && expected_hits.size() == 0)
      $display("ray_box_slab_intersection_tb OK");
    else
      $display("ray_box_slab_intersection_tb NOT OK");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout waiting for results.");
    $display("ray_box_slab_intersection_tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
